@@ design/rbka_pkg.sv @@
// Shared types, constants and helper functions of the RPM-binned knock averager.
`default_nettype none

package rbka_pkg;

  localparam int unsigned BIN_COUNT       = 128;
  localparam int unsigned SAMPLES_PER_BIN = 8;

  localparam int unsigned SPEED_W  = 14;
  localparam int unsigned KNOCK_W  = 12;
  localparam int unsigned SEL_W    = 7;
  localparam int unsigned ORIGIN_W = 12;
  localparam int unsigned STEP_W   = 10;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned AVG_W    = 12;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 12;

  localparam int unsigned BIN_W    = $clog2(BIN_COUNT);
  localparam int unsigned PTR_W    = (SAMPLES_PER_BIN > 1) ? $clog2(SAMPLES_PER_BIN) : 1;
  localparam int unsigned CNT_W    = $clog2(SAMPLES_PER_BIN + 1);
  localparam int unsigned SUM_W    = KNOCK_W + $clog2(SAMPLES_PER_BIN);
  localparam int unsigned STORE_AW = $clog2(BIN_COUNT * SAMPLES_PER_BIN);

  localparam int unsigned NUM_W    = SPEED_W + 2;
  localparam int unsigned DIV_W    = STEP_W + 1;
  localparam int unsigned NITER_W  = $clog2(NUM_W);
  localparam int unsigned SITER_W  = $clog2(SUM_W);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = ORIGIN_W'(200);
  localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(60);

  localparam logic [NITER_W-1:0] NUM_LAST   = NITER_W'(NUM_W - 1);
  localparam logic [SITER_W-1:0] SUM_LAST   = SITER_W'(SUM_W - 1);
  localparam logic [NUM_W-1:0]   BIN_MAX_Q  = NUM_W'(BIN_COUNT - 1);
  localparam logic [BIN_W-1:0]   BIN_LAST   = BIN_W'(BIN_COUNT - 1);
  localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(SAMPLES_PER_BIN - 1);
  localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(SAMPLES_PER_BIN);
  localparam logic [QCNT_W-1:0]  QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_CLEAR_ALL = 2'd1,
    CMD_CLEAR_ONE = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RPM_ORIGIN = 1'b0,
    CFG_RPM_STEP   = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_META,
    B_OLD,
    B_DIV,
    B_OUT
  } back_state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [SPEED_W-1:0] engine_speed;
    logic [KNOCK_W-1:0] knock_level;
    logic [SEL_W-1:0]   bin_select;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] bin_index;
    logic               stored;
    logic [COUNT_W-1:0] sample_count;
    logic [AVG_W-1:0]   bin_average;
  } out_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [BIN_W-1:0]   bin;
    logic [KNOCK_W-1:0] knock;
    logic               rising;
    logic               sel_ok;
  } job_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [PTR_W-1:0] ptr;
    logic [SUM_W-1:0] sum;
  } meta_t;

  function automatic logic [BIN_W-1:0] sel_to_bin(logic [SEL_W-1:0] sel);
    return BIN_W'(sel);
  endfunction

  function automatic logic sel_in_range(logic [SEL_W-1:0] sel);
    return 32'(sel) < BIN_COUNT;
  endfunction

  function automatic logic [INDEX_W-1:0] bin_to_index(logic [BIN_W-1:0] bin);
    return INDEX_W'(bin);
  endfunction

  function automatic logic [COUNT_W-1:0] cnt_to_count(logic [CNT_W-1:0] cnt);
    return COUNT_W'(cnt);
  endfunction

  function automatic logic [SUM_W-1:0] knock_to_sum(logic [KNOCK_W-1:0] k);
    return SUM_W'(k);
  endfunction

  function automatic logic [STORE_AW-1:0] store_addr(int unsigned bin, int unsigned slot);
    return STORE_AW'(bin * SAMPLES_PER_BIN + slot);
  endfunction

endpackage

`default_nettype wire

@@ design/rpm_binned_knock_averager_top.sv @@
// The front end takes one transaction at a time and runs a 16-step bin divider for each sample.
// The back end takes one job at a time and runs a 15-step average divider for each sample or read,
// with an extra read of the oldest sample when a sample goes into a full bin; clears skip the divider.
// The two ends work concurrently, decoupled by a two-entry queue.
// Reset clears bin counts, sums and pointers at once through per-bin valid flags;
// there is no clearing pass, and the sample memory holds undefined data until written.
`default_nettype none

module rpm_binned_knock_averager_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rbka_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [rbka_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire rbka_pkg::in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output rbka_pkg::out_t                        out_data_o
);

  logic           push_valid;
  logic           push_ready;
  rbka_pkg::job_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  rbka_pkg::job_t pop_data;

  rbka_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_data)
  );

  rbka_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rbka_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ design/rbka_front.sv @@
// Front end: configuration registers, input acceptance and iterative speed-to-bin division.
`default_nettype none

module rbka_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rbka_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire logic [rbka_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire rbka_pkg::in_t                       in_data_i,
  output logic                                     job_valid_o,
  input  wire logic                                job_ready_i,
  output rbka_pkg::job_t                           job_o
);

  rbka_pkg::front_state_e             state_q, state_d;
  logic [rbka_pkg::ORIGIN_W-1:0]      origin_q;
  logic [rbka_pkg::STEP_W-1:0]        step_q;
  logic [rbka_pkg::SPEED_W-1:0]       prev_speed_q;
  logic [rbka_pkg::NUM_W-1:0]         num_q, num_d;
  logic [rbka_pkg::DIV_W-1:0]         rem_q, rem_d;
  logic [rbka_pkg::DIV_W-1:0]         div_q;
  logic [rbka_pkg::NITER_W-1:0]       iter_q;
  rbka_pkg::job_t                     job_q;

  logic                               accept;
  logic [rbka_pkg::STEP_W-1:0]        step_eff;
  logic                               below;
  logic [rbka_pkg::SPEED_W-1:0]       diff;
  logic [rbka_pkg::NUM_W-1:0]         num_init;
  logic [rbka_pkg::DIV_W:0]           trial;
  logic [rbka_pkg::DIV_W:0]           sub;
  logic                               ge;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    step_eff = (step_q == '0) ? rbka_pkg::STEP_W'(1) : step_q;
    below    = in_data_i.engine_speed < rbka_pkg::SPEED_W'(origin_q);
    diff     = in_data_i.engine_speed - rbka_pkg::SPEED_W'(origin_q);
    num_init = below ? '0
                     : (rbka_pkg::NUM_W'({diff, 1'b0}) + rbka_pkg::NUM_W'(step_eff));
    trial    = {rem_q, num_q[rbka_pkg::NUM_W-1]};
    sub      = trial - {1'b0, div_q};
    ge       = trial >= {1'b0, div_q};
    rem_d    = ge ? sub[rbka_pkg::DIV_W-1:0] : trial[rbka_pkg::DIV_W-1:0];
    num_d    = {num_q[rbka_pkg::NUM_W-2:0], ge};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rbka_pkg::F_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.cmd == rbka_pkg::CMD_SAMPLE) ? rbka_pkg::F_DIV
                                                            : rbka_pkg::F_PUSH;
        end
      end
      rbka_pkg::F_DIV: begin
        if (iter_q == '0) begin
          state_d = rbka_pkg::F_PUSH;
        end
      end
      rbka_pkg::F_PUSH: begin
        if (job_ready_i) begin
          state_d = rbka_pkg::F_IDLE;
        end
      end
      default: state_d = rbka_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == rbka_pkg::F_IDLE);
    job_valid_o = (state_q == rbka_pkg::F_PUSH);
    job_o       = job_q;
    if (job_q.cmd == rbka_pkg::CMD_SAMPLE) begin
      job_o.bin = (num_q > rbka_pkg::BIN_MAX_Q) ? rbka_pkg::BIN_LAST
                                                : num_q[rbka_pkg::BIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rbka_pkg::F_IDLE;
      origin_q     <= rbka_pkg::ORIGIN_RESET;
      step_q       <= rbka_pkg::STEP_RESET;
      prev_speed_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rbka_pkg::CFG_RPM_ORIGIN: origin_q <= cfg_data_i[rbka_pkg::ORIGIN_W-1:0];
          rbka_pkg::CFG_RPM_STEP:   step_q   <= cfg_data_i[rbka_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      if (accept && (in_data_i.cmd == rbka_pkg::CMD_SAMPLE)) begin
        prev_speed_q <= in_data_i.engine_speed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.cmd    <= in_data_i.cmd;
      job_q.bin    <= rbka_pkg::sel_to_bin(in_data_i.bin_select);
      job_q.knock  <= in_data_i.knock_level;
      job_q.rising <= in_data_i.engine_speed > prev_speed_q;
      job_q.sel_ok <= (in_data_i.cmd == rbka_pkg::CMD_SAMPLE) ||
                      rbka_pkg::sel_in_range(in_data_i.bin_select);
      num_q        <= num_init;
      rem_q        <= '0;
      div_q        <= {step_eff, 1'b0};
      iter_q       <= rbka_pkg::NUM_LAST;
    end else if (state_q == rbka_pkg::F_DIV) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      iter_q <= iter_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ design/rbka_queue.sv @@
// Two-entry queue carrying classified transactions from the front end to the back end.
`default_nettype none

module rbka_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire rbka_pkg::job_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output rbka_pkg::job_t      pop_data_o
);

  rbka_pkg::job_t                entries_q [rbka_pkg::QUEUE_DEPTH];
  logic [rbka_pkg::QPTR_W-1:0]   wr_ptr_q;
  logic [rbka_pkg::QPTR_W-1:0]   rd_ptr_q;
  logic [rbka_pkg::QCNT_W-1:0]   count_q;
  logic                          push;
  logic                          pop;

  assign push_ready_o = (count_q != rbka_pkg::QUEUE_FULL);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ design/rbka_back.sv @@
// Back end: bin metadata and sample memories, ring update, iterative average and result register.
`default_nettype none

module rbka_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  output logic                job_ready_o,
  input  wire rbka_pkg::job_t job_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rbka_pkg::out_t      out_data_o
);

  rbka_pkg::back_state_e           state_q, state_d;
  logic [rbka_pkg::BIN_COUNT-1:0]  valid_q;
  rbka_pkg::job_t                  job_q;
  rbka_pkg::meta_t                 meta_q;
  rbka_pkg::meta_t                 meta_rd_q;
  logic [rbka_pkg::KNOCK_W-1:0]    store_rd_q;
  logic [rbka_pkg::SUM_W-1:0]      dq_q, dq_d;
  logic [rbka_pkg::CNT_W-1:0]      rem_q, rem_d;
  logic [rbka_pkg::SITER_W-1:0]    iter_q;
  rbka_pkg::out_t                  res_q;

  rbka_pkg::meta_t                 meta_mem [rbka_pkg::BIN_COUNT];
  logic [rbka_pkg::KNOCK_W-1:0]    store_mem [rbka_pkg::BIN_COUNT * rbka_pkg::SAMPLES_PER_BIN];

  logic                            pop;
  logic                            do_store;
  logic                            bin_full;
  rbka_pkg::meta_t                 meta_cur;
  rbka_pkg::meta_t                 meta_wdata;
  logic                            meta_we;
  logic                            store_we;
  logic                            store_re;
  logic [rbka_pkg::STORE_AW-1:0]   store_addr;
  logic                            div_start;
  rbka_pkg::meta_t                 div_meta;
  logic [rbka_pkg::CNT_W:0]        trial;
  logic [rbka_pkg::CNT_W:0]        sub;
  logic                            ge;

  assign pop = job_valid_i && job_ready_o;

  always_comb begin
    meta_cur   = (valid_q[job_q.bin] && job_q.sel_ok) ? meta_rd_q : '0;
    do_store   = (job_q.cmd == rbka_pkg::CMD_SAMPLE) && job_q.rising;
    bin_full   = (meta_cur.count >= rbka_pkg::CNT_FULL);
    meta_we    = 1'b0;
    store_we   = 1'b0;
    store_re   = 1'b0;
    div_start  = 1'b0;
    div_meta   = meta_cur;
    meta_wdata = meta_cur;
    store_addr = rbka_pkg::store_addr(job_q.bin, meta_q.ptr);
    if (state_q == rbka_pkg::B_META) begin
      if (do_store && bin_full) begin
        store_re   = 1'b1;
        store_addr = rbka_pkg::store_addr(job_q.bin, meta_cur.ptr);
      end else begin
        div_start = 1'b1;
        if (do_store) begin
          store_we         = 1'b1;
          store_addr       = rbka_pkg::store_addr(job_q.bin, meta_cur.count);
          meta_we          = 1'b1;
          meta_wdata.count = meta_cur.count + 1'b1;
          meta_wdata.sum   = meta_cur.sum + rbka_pkg::knock_to_sum(job_q.knock);
          div_meta         = meta_wdata;
        end
      end
    end else if (state_q == rbka_pkg::B_OLD) begin
      div_start        = 1'b1;
      store_we         = 1'b1;
      meta_we          = 1'b1;
      meta_wdata       = meta_q;
      meta_wdata.ptr   = (meta_q.ptr == rbka_pkg::PTR_LAST) ? '0 : meta_q.ptr + 1'b1;
      meta_wdata.sum   = meta_q.sum - rbka_pkg::knock_to_sum(store_rd_q)
                         + rbka_pkg::knock_to_sum(job_q.knock);
      div_meta         = meta_wdata;
    end
  end

  always_comb begin
    trial = {rem_q, dq_q[rbka_pkg::SUM_W-1]};
    sub   = trial - {1'b0, meta_q.count};
    ge    = trial >= {1'b0, meta_q.count};
    rem_d = ge ? sub[rbka_pkg::CNT_W-1:0] : trial[rbka_pkg::CNT_W-1:0];
    dq_d  = {dq_q[rbka_pkg::SUM_W-2:0], ge};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rbka_pkg::B_IDLE: begin
        if (pop) begin
          if ((job_i.cmd == rbka_pkg::CMD_CLEAR_ALL) ||
              (job_i.cmd == rbka_pkg::CMD_CLEAR_ONE)) begin
            state_d = rbka_pkg::B_OUT;
          end else begin
            state_d = rbka_pkg::B_META;
          end
        end
      end
      rbka_pkg::B_META: state_d = div_start ? rbka_pkg::B_DIV : rbka_pkg::B_OLD;
      rbka_pkg::B_OLD:  state_d = rbka_pkg::B_DIV;
      rbka_pkg::B_DIV: begin
        if (iter_q == '0) begin
          state_d = rbka_pkg::B_OUT;
        end
      end
      rbka_pkg::B_OUT: begin
        if (out_ready_i) begin
          state_d = rbka_pkg::B_IDLE;
        end
      end
      default: state_d = rbka_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = (state_q == rbka_pkg::B_IDLE);
    out_valid_o = (state_q == rbka_pkg::B_OUT);
    out_data_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbka_pkg::B_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (pop && (job_i.cmd == rbka_pkg::CMD_CLEAR_ALL)) begin
        valid_q <= '0;
      end else if (pop && (job_i.cmd == rbka_pkg::CMD_CLEAR_ONE) && job_i.sel_ok) begin
        valid_q[job_i.bin] <= 1'b0;
      end else if (meta_we) begin
        valid_q[job_q.bin] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      meta_rd_q <= meta_mem[job_i.bin];
    end
    if (meta_we) begin
      meta_mem[job_q.bin] <= meta_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_re) begin
      store_rd_q <= store_mem[store_addr];
    end
    if (store_we) begin
      store_mem[store_addr] <= job_q.knock;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      job_q                  <= job_i;
      res_q.bin_index        <= (job_i.cmd == rbka_pkg::CMD_CLEAR_ALL) ? '0
                                : rbka_pkg::bin_to_index(job_i.bin);
      res_q.stored           <= 1'b0;
      res_q.sample_count     <= '0;
      res_q.bin_average      <= '0;
    end else if (state_q == rbka_pkg::B_META) begin
      res_q.stored     <= do_store;
      if (!div_start) begin
        meta_q <= meta_cur;
      end
    end
    if (div_start) begin
      meta_q             <= div_meta;
      dq_q               <= div_meta.sum;
      rem_q              <= '0;
      iter_q             <= rbka_pkg::SUM_LAST;
      res_q.sample_count <= rbka_pkg::cnt_to_count(div_meta.count);
    end else if (state_q == rbka_pkg::B_DIV) begin
      dq_q   <= dq_d;
      rem_q  <= rem_d;
      iter_q <= iter_q - 1'b1;
      if (iter_q == '0) begin
        res_q.bin_average <= (meta_q.count == '0) ? '0 : dq_d[rbka_pkg::AVG_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ test/rpm_binned_knock_averager_top_tb.sv @@
// Self-checking testbench for the RPM-binned knock averager, with a predictor of every result.
`timescale 1ns / 1ps

module rpm_binned_knock_averager_top_tb;

  localparam int unsigned SPEED_MAX    = (1 << rbka_pkg::SPEED_W) - 1;
  localparam int unsigned KNOCK_MAX    = (1 << rbka_pkg::KNOCK_W) - 1;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned HOLD_CYCLES  = 600;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             cfg_we    = 1'b0;
  logic [rbka_pkg::CFG_INDEX_W-1:0] cfg_index = rbka_pkg::CFG_RPM_ORIGIN;
  logic [rbka_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                             in_valid  = 1'b0;
  rbka_pkg::in_t                    in_data   = '0;
  logic                             out_ready = 1'b0;
  logic                             in_ready;
  logic                             out_valid;
  rbka_pkg::out_t                   out_data;

  logic [rbka_pkg::KNOCK_W-1:0] knock_ring [rbka_pkg::BIN_COUNT][rbka_pkg::SAMPLES_PER_BIN];
  int unsigned                  ring_fill  [rbka_pkg::BIN_COUNT];
  int unsigned                  ring_next  [rbka_pkg::BIN_COUNT];
  int unsigned                  ring_total [rbka_pkg::BIN_COUNT];
  int unsigned                  last_speed;
  int unsigned                  model_origin;
  int unsigned                  model_step;
  rbka_pkg::out_t               expected_results [$];

  int unsigned errors          = 0;
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned samples_stored  = 0;
  int unsigned reg_writes      = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned stall_pct       = 0;
  int unsigned ramp_speed      = 0;
  logic        holding         = 1'b0;
  event        hold_start;

  rpm_binned_knock_averager_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #20ms;
    $display("rpm_binned_knock_averager_top_tb failed");
    $finish;
  end

  function automatic void clear_ring(int unsigned b);
    ring_fill[b]  = 0;
    ring_next[b]  = 0;
    ring_total[b] = 0;
  endfunction

  function automatic int unsigned speed_to_bin(int unsigned speed);
    int unsigned bin_width;
    int unsigned idx;
    bin_width = (model_step == 0) ? 1 : model_step;
    if (speed < model_origin) return 0;
    idx = (2 * (speed - model_origin) + bin_width) / (2 * bin_width);
    return (idx > rbka_pkg::BIN_COUNT - 1) ? rbka_pkg::BIN_COUNT - 1 : idx;
  endfunction

  function automatic rbka_pkg::out_t ring_summary(int unsigned b, logic stored);
    rbka_pkg::out_t r;
    r.bin_index    = rbka_pkg::INDEX_W'(b);
    r.stored       = stored;
    r.sample_count = rbka_pkg::COUNT_W'(ring_fill[b]);
    r.bin_average  = (ring_fill[b] == 0) ? '0
                                         : rbka_pkg::AVG_W'(ring_total[b] / ring_fill[b]);
    return r;
  endfunction

  function automatic rbka_pkg::out_t predict_result(rbka_pkg::in_t it);
    rbka_pkg::out_t r;
    int unsigned    b;
    int unsigned    sel;
    int unsigned    slot;
    int unsigned    speed;
    int unsigned    knock;
    logic           rising;
    r     = '0;
    sel   = 32'(it.bin_select);
    speed = 32'(it.engine_speed);
    knock = 32'(it.knock_level);
    case (it.cmd)
      rbka_pkg::CMD_SAMPLE: begin
        b      = speed_to_bin(speed);
        rising = speed > last_speed;
        if (rising) begin
          samples_stored++;
          if (ring_fill[b] < rbka_pkg::SAMPLES_PER_BIN) begin
            knock_ring[b][ring_fill[b]] = it.knock_level;
            ring_total[b] += knock;
            ring_fill[b]++;
          end else begin
            slot = ring_next[b];
            ring_total[b] = ring_total[b] - 32'(knock_ring[b][slot]) + knock;
            knock_ring[b][slot] = it.knock_level;
            ring_next[b] = (slot + 1) % rbka_pkg::SAMPLES_PER_BIN;
          end
        end
        last_speed = speed;
        r = ring_summary(b, rising);
      end
      rbka_pkg::CMD_CLEAR_ALL: begin
        for (int i = 0; i < rbka_pkg::BIN_COUNT; i++) clear_ring(i);
      end
      rbka_pkg::CMD_CLEAR_ONE: begin
        if (sel < rbka_pkg::BIN_COUNT) clear_ring(sel);
        r.bin_index = rbka_pkg::INDEX_W'(sel);
      end
      rbka_pkg::CMD_READ: begin
        if (sel < rbka_pkg::BIN_COUNT) r = ring_summary(sel, 1'b0);
        else r.bin_index = rbka_pkg::INDEX_W'(sel);
      end
    endcase
    return r;
  endfunction

  function automatic rbka_pkg::in_t pack_item(rbka_pkg::cmd_e c, int unsigned speed,
                                              int unsigned knock, int unsigned sel);
    rbka_pkg::in_t it;
    it.cmd          = c;
    it.engine_speed = rbka_pkg::SPEED_W'(speed);
    it.knock_level  = rbka_pkg::KNOCK_W'(knock);
    it.bin_select   = rbka_pkg::SEL_W'(sel);
    return it;
  endfunction

  // Mostly slow speed ramps so that bins fill and wrap, with dips, repeats and commands mixed in.
  function automatic rbka_pkg::in_t random_item();
    rbka_pkg::in_t it;
    int unsigned   pick;
    int unsigned   dip;
    int unsigned   span;
    int unsigned   lim;
    it   = pack_item(rbka_pkg::CMD_SAMPLE, $urandom_range(0, SPEED_MAX),
                     $urandom_range(0, KNOCK_MAX), $urandom_range(0, rbka_pkg::BIN_COUNT - 1));
    pick = $urandom_range(0, 99);
    span = (model_step > 6) ? model_step / 6 : 1;
    if (pick < 75) begin
      dip = $urandom_range(0, 99);
      if (dip < 3 || ramp_speed + span > SPEED_MAX) begin
        lim = model_origin + rbka_pkg::BIN_COUNT * ((model_step == 0) ? 1 : model_step);
        if (lim > SPEED_MAX) lim = SPEED_MAX;
        ramp_speed = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SPEED_MAX)
                                                 : $urandom_range(0, lim);
      end else if (dip < 88) begin
        ramp_speed += $urandom_range(1, span);
      end else if (dip >= 94) begin
        ramp_speed -= (ramp_speed > 4 * span) ? $urandom_range(1, 4 * span) : ramp_speed;
      end
      it.engine_speed = rbka_pkg::SPEED_W'(ramp_speed);
      if ($urandom_range(0, 9) == 0) it.knock_level = $urandom_range(0, 1) ? '1 : '0;
    end else if (pick < 83) begin
      it.cmd = rbka_pkg::CMD_READ;
    end else if (pick < 90) begin
      it.cmd        = rbka_pkg::CMD_READ;
      it.bin_select = rbka_pkg::SEL_W'(speed_to_bin(ramp_speed));
    end else if (pick < 95) begin
      it.cmd = rbka_pkg::CMD_CLEAR_ONE;
    end else if (pick < 99) begin
      it.cmd        = rbka_pkg::CMD_CLEAR_ONE;
      it.bin_select = rbka_pkg::SEL_W'(speed_to_bin(ramp_speed));
    end else begin
      it.cmd = rbka_pkg::CMD_CLEAR_ALL;
    end
    return it;
  endfunction

  task automatic send_item(input rbka_pkg::in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.insert(expected_results.size(), predict_result(it));
    items_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input rbka_pkg::cfg_index_e idx, input int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= rbka_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == rbka_pkg::CFG_RPM_ORIGIN) model_origin = value % (1 << rbka_pkg::ORIGIN_W);
    else model_step = value % (1 << rbka_pkg::STEP_W);
    reg_writes++;
  endtask

  task automatic set_registers(input int unsigned origin, input int unsigned step);
    write_reg(rbka_pkg::CFG_RPM_ORIGIN, origin);
    write_reg(rbka_pkg::CFG_RPM_STEP, step);
  endtask

  task automatic check_field(input string field, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct    <= 0;
    send_item(pack_item(rbka_pkg::CMD_READ, SPEED_MAX, KNOCK_MAX, 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 0, KNOCK_MAX, rbka_pkg::BIN_COUNT - 1));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 100, KNOCK_MAX, 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 230, 0, 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 229, 1234, 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, SPEED_MAX, KNOCK_MAX, 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, SPEED_MAX, 1, 0));
    send_item(pack_item(rbka_pkg::CMD_READ, 0, 0, rbka_pkg::BIN_COUNT - 1));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 0, 0, 0));
    for (int i = 0; i < 10; i++) begin
      send_item(pack_item(rbka_pkg::CMD_SAMPLE, 470 + i,
                          (i % 3 == 0) ? KNOCK_MAX : (i % 3 == 1) ? 0 : $urandom_range(0, KNOCK_MAX),
                          0));
    end
    send_item(pack_item(rbka_pkg::CMD_READ, 0, 0, 5));
    send_item(pack_item(rbka_pkg::CMD_CLEAR_ONE, SPEED_MAX, KNOCK_MAX, 5));
    send_item(pack_item(rbka_pkg::CMD_READ, 0, 0, 5));
    send_item(pack_item(rbka_pkg::CMD_CLEAR_ALL, SPEED_MAX, KNOCK_MAX, rbka_pkg::BIN_COUNT - 1));
    send_item(pack_item(rbka_pkg::CMD_READ, 0, 0, rbka_pkg::BIN_COUNT - 1));
    send_item(pack_item(rbka_pkg::CMD_READ, 0, 0, 1));
  endtask

  task automatic test_register_extremes();
    wait_for_drain();
    set_registers((1 << rbka_pkg::ORIGIN_W) - 1, 0);
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 4094, $urandom_range(0, KNOCK_MAX), 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 4095, $urandom_range(0, KNOCK_MAX), 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 4096, $urandom_range(0, KNOCK_MAX), 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 4200, $urandom_range(0, KNOCK_MAX), 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, SPEED_MAX, $urandom_range(0, KNOCK_MAX), 0));
    wait_for_drain();
    set_registers(0, (1 << rbka_pkg::STEP_W) - 1);
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 0, KNOCK_MAX, 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 511, KNOCK_MAX, 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 512, 0, 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, SPEED_MAX, KNOCK_MAX, 0));
    send_item(pack_item(rbka_pkg::CMD_READ, 0, 0, 16));
    wait_for_drain();
    set_registers(0, 1);
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 0, 0, 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 1, 7, 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 126, 8, 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 127, 9, 0));
    send_item(pack_item(rbka_pkg::CMD_SAMPLE, 200, 10, 0));
    send_item(pack_item(rbka_pkg::CMD_READ, 0, 0, rbka_pkg::BIN_COUNT - 1));
    wait_for_drain();
    set_registers(32'(rbka_pkg::ORIGIN_RESET), 32'(rbka_pkg::STEP_RESET));
  endtask

  task automatic test_random_phase(input int unsigned send_pct, input int unsigned stall_v,
                                   input int unsigned count);
    wait_for_drain();
    set_registers($urandom_range(0, (1 << rbka_pkg::ORIGIN_W) - 1),
                  ($urandom_range(0, 9) < 7) ? $urandom_range(20, 150)
                                             : $urandom_range(0, (1 << rbka_pkg::STEP_W) - 1));
    send_idle_pct = send_pct;
    stall_pct    <= stall_v;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_drain();
      send_item(random_item());
    end
  endtask

  task automatic test_backpressure();
    wait_for_drain();
    send_idle_pct = 0;
    stall_pct    <= 0;
    -> hold_start;
    for (int i = 0; i < 40; i++) send_item(random_item());
  endtask

  initial forever begin
    @(hold_start);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= !holding && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    rbka_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, expected none, actual %h", $time, out_data);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        check_field("bin_index", 16'(want.bin_index), 16'(out_data.bin_index));
        check_field("stored", 16'(want.stored), 16'(out_data.stored));
        check_field("sample_count", 16'(want.sample_count), 16'(out_data.sample_count));
        check_field("bin_average", 16'(want.bin_average), 16'(out_data.bin_average));
      end
    end
  end

  initial begin
    for (int i = 0; i < rbka_pkg::BIN_COUNT; i++) clear_ring(i);
    last_speed   = 0;
    model_origin = 32'(rbka_pkg::ORIGIN_RESET);
    model_step   = 32'(rbka_pkg::STEP_RESET);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_register_extremes();
    test_random_phase(0, 0, 330);
    test_random_phase(56, 0, 330);
    test_random_phase(0, 56, 330);
    test_backpressure();
    test_random_phase(37, 37, 330);
    wait_for_drain();
    $display("Run covered %0d transactions in and %0d results out, %0d of them stored samples.",
             items_sent, results_checked, samples_stored);
    $display("%0d register writes incl. zero and full step, four idle/stall mixes, a long hold.",
             reg_writes);
    if (errors == 0) begin
      $display("rpm_binned_knock_averager_top_tb passed");
    end else begin
      $display("rpm_binned_knock_averager_top_tb failed");
    end
    $finish;
  end

endmodule
